/* hw/rtl/mtrd_pkg.sv */
// Shared constants, types and word functions for the range-draw generator.
package mtrd_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ADDR_W       = 10;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [31:0]       word_t;

  // Last word index, the read position codes beyond it, and the far-neighbour split and offset.
  localparam addr_t POS_LAST    = addr_t'(STATE_WORDS - 1);
  localparam addr_t POS_USED    = addr_t'(STATE_WORDS);
  localparam addr_t POS_PENDING = addr_t'(STATE_WORDS + 1);
  localparam addr_t FAR_SPLIT   = addr_t'(STATE_WORDS - TWIST_OFFSET);
  localparam addr_t FAR_OFFSET  = addr_t'(TWIST_OFFSET);

  localparam word_t SEED_RESET = 32'd4357;
  localparam logic [16:0] SEED_MULT = 17'd69069;
  localparam word_t MAT_A      = 32'h9908_b0df;
  localparam word_t UP_MASK    = 32'h8000_0000;
  localparam word_t LO_MASK    = 32'h7fff_ffff;
  localparam word_t TEMPER_B   = 32'h9d2c_5680;
  localparam word_t TEMPER_C   = 32'hefc6_0000;

  // One access to the state store.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } store_req_t;

  function automatic word_t mix(word_t hi_src, word_t lo_src, word_t far_src);
    word_t y;
    y = (hi_src & UP_MASK) | (lo_src & LO_MASK);
    return far_src ^ (y >> 1) ^ (y[0] ? MAT_A : 32'd0);
  endfunction

  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* hw/rtl/mtrd_store.sv */
// State store of the generator: one write port, one registered read port.
module mtrd_store import mtrd_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output word_t      rdata
);

  word_t mem [STATE_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

/* hw/rtl/mtrd_modulo.sv */
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module mtrd_modulo import mtrd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t remainder
);

  logic        busy;
  logic [4:0]  cnt;
  word_t       dvd;
  word_t       dsr;
  word_t       rem;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  // Shift in the next dividend bit and subtract where it fits.
  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= fits ? diff[31:0] : trial[31:0];
    end
  end

  assign remainder = rem;

endmodule

/* hw/rtl/mersenne_twister_range_draw_top.sv */
// Top level: range draw from a 32-bit Mersenne twister with lazy reseed and twist.
//
// Usage. A request on req_valid/req_stall carries range_bound; the block
// answers with one draw_value on rsp_valid/rsp_stall, equal to the next
// tempered generator word modulo range_bound, or 0 for a zero bound (the
// generator is then left as it was). Requests are taken one at a time:
// req_stall is high from acceptance until the result has moved into the
// output register, which then holds it for as long as rsp_stall is high
// while the next request is already being worked on.
// A nonzero request passes through S_RD_ISS, S_RD_WAIT, S_MOD (the 32-step
// serial remainder unit) and S_DONE before rsp_valid rises; a zero-bound
// request goes straight to S_DONE. Every 624th nonzero draw first twists
// the store, reading each word's next and far neighbours and then writing
// the word back; after reset or a seed write the first nonzero draw also
// refills the store from the seed, one word per cycle, before the twist.
// Seed: seed_write with seed_data stores the seed and marks a reseed; write
// it only while the block is idle. Reset loads seed 4357 and marks a
// reseed; the store itself is never cleared, it is always refilled before
// it is read.
module mersenne_twister_range_draw_top import mtrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_write,
  input  logic [31:0] seed_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [31:0] range_bound,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] draw_value
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SEED    = 4'd1;
  localparam logic [3:0] S_TW_PRE  = 4'd2;
  localparam logic [3:0] S_TW_RNXT = 4'd3;
  localparam logic [3:0] S_TW_RFAR = 4'd4;
  localparam logic [3:0] S_TW_WR   = 4'd5;
  localparam logic [3:0] S_RD_ISS  = 4'd6;
  localparam logic [3:0] S_RD_WAIT = 4'd7;
  localparam logic [3:0] S_MOD     = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  addr_t      pos;
  addr_t      idx;
  word_t      seed;
  word_t      bound;
  word_t      cur;
  word_t      hi;
  word_t      lo;
  word_t      result;

  store_req_t store_req;
  word_t      rdata;
  addr_t      nxt_addr;
  addr_t      far_addr;
  logic       req_take;
  logic       out_load;
  logic       mod_start;
  logic       mod_done;
  word_t      mod_rem;
  logic [48:0] seed_prod;

  mtrd_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (rdata)
  );

  mtrd_modulo u_modulo (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (temper(rdata)),
    .divisor   (bound),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  assign mod_start = (state == S_RD_WAIT);

  // Neighbours of word idx in the in-place twist.
  assign nxt_addr  = (idx == POS_LAST) ? '0 : idx + addr_t'(1);
  assign far_addr  = (idx < FAR_SPLIT) ? idx + FAR_OFFSET : idx - FAR_SPLIT;
  assign seed_prod = cur * SEED_MULT;

  // Store port: refill writes, twist reads and writes, draw reads.
  always_comb begin
    store_req.we    = 1'b0;
    store_req.waddr = idx;
    store_req.wdata = cur;
    store_req.raddr = '0;
    case (state)
      S_SEED: begin
        store_req.we = 1'b1;
      end
      S_TW_RNXT: begin
        store_req.raddr = nxt_addr;
      end
      S_TW_RFAR: begin
        store_req.raddr = far_addr;
      end
      S_TW_WR: begin
        store_req.we    = 1'b1;
        store_req.wdata = mix(hi, lo, rdata);
      end
      S_RD_ISS: begin
        store_req.raddr = pos;
      end
      default: begin
        store_req.raddr = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_take) begin
          if (range_bound == 32'd0) begin
            state_next = S_DONE;
          end else if (pos == POS_PENDING) begin
            state_next = S_SEED;
          end else if (pos == POS_USED) begin
            state_next = S_TW_PRE;
          end else begin
            state_next = S_RD_ISS;
          end
        end
      end
      S_SEED: begin
        if (idx == POS_LAST) begin
          state_next = S_TW_PRE;
        end
      end
      S_TW_PRE:  state_next = S_TW_RNXT;
      S_TW_RNXT: state_next = S_TW_RFAR;
      S_TW_RFAR: state_next = S_TW_WR;
      S_TW_WR: begin
        state_next = (idx == POS_LAST) ? S_RD_ISS : S_TW_RNXT;
      end
      S_RD_ISS:  state_next = S_RD_WAIT;
      S_RD_WAIT: state_next = S_MOD;
      S_MOD: begin
        if (mod_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= POS_PENDING;
      seed      <= SEED_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Drop remaining words and mark a reseed on every seed write.
      if (seed_write) begin
        seed <= seed_data;
        pos  <= POS_PENDING;
      end else if (state == S_TW_WR && idx == POS_LAST) begin
        pos <= '0;
      end else if (state == S_RD_WAIT) begin
        pos <= pos + addr_t'(1);
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (req_take) begin
      bound  <= range_bound;
      idx    <= '0;
      cur    <= seed;
      result <= '0;
    end
    case (state)
      S_SEED: begin
        cur <= seed_prod[31:0];
        idx <= (idx == POS_LAST) ? '0 : idx + addr_t'(1);
      end
      S_TW_RNXT: begin
        // Word 0 arrives from the pre-read at the start of the pass.
        if (idx == '0) begin
          hi <= rdata;
        end
      end
      S_TW_RFAR: begin
        lo <= rdata;
      end
      S_TW_WR: begin
        hi  <= lo;
        idx <= (idx == POS_LAST) ? '0 : idx + addr_t'(1);
      end
      S_MOD: begin
        if (mod_done) begin
          result <= mod_rem;
        end
      end
      default: begin
        hi <= hi;
      end
    endcase
    if (out_load) begin
      draw_value <= result;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_PENDING)
    else $error("read position beyond reseed mark");

  a_store_write: assert property (@(posedge clk) disable iff (rst)
    store_req.we |-> (state == S_SEED || state == S_TW_WR))
    else $error("store written outside refill or twist");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("remainder unit finished while not awaited");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && bound != 32'd0) |-> result < bound)
    else $error("draw not below its bound");

  a_twist_to_draw: assert property (@(posedge clk) disable iff (rst)
    (state == S_TW_WR && idx == POS_LAST && !seed_write) |=> (pos == '0 && state == S_RD_ISS))
    else $error("twist pass did not hand over to the draw at word 0");
`endif

endmodule
